### rtl/ssa_pkg.sv
// Shared types, codes and sizes for the sparse symmetric scatter-add block.
// No dependencies; used by every module of the block.
package ssa_pkg;

   localparam int DofDepth   = 4096;
   localparam int EqDepth    = 4096;
   localparam int NzDepth    = 65536;
   localparam int DofAw      = $clog2(DofDepth);
   localparam int EqAw       = $clog2(EqDepth + 1);
   localparam int NzAw       = $clog2(NzDepth);
   localparam int QueueDepth = 2;

   localparam int ReqDataW = 128;
   localparam int RspDataW = 112;

   localparam logic [2:0] CMD_DOF_WR = 3'd0;
   localparam logic [2:0] CMD_COL_WR = 3'd1;
   localparam logic [2:0] CMD_ROW_WR = 3'd2;
   localparam logic [2:0] CMD_ACCUM  = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;
   localparam logic [2:0] CMD_VAL_WR = 3'd5;

   localparam logic [2:0] ST_DONE        = 3'd0;
   localparam logic [2:0] ST_LOWER       = 3'd1;
   localparam logic [2:0] ST_CONSTRAINED = 3'd2;
   localparam logic [2:0] ST_NO_POS      = 3'd3;
   localparam logic [2:0] ST_SATURATED   = 3'd4;

   localparam logic [16:0] CONSTRAINED_WORD = 17'h1FFFF;

   typedef enum logic [2:0] {
      OP_IMMEDIATE,
      OP_COL_WR,
      OP_ROW_WR,
      OP_ACCUM,
      OP_READ,
      OP_VAL_WR
   } op_type;

   // one classified word between front and back
   typedef struct packed {
      op_type             op;
      logic [2:0]         status;
      logic [15:0]        addr;
      logic [16:0]        data;
      logic [12:0]        eq_r;
      logic [12:0]        eq_c;
      logic signed [31:0] vre;
      logic signed [31:0] vim;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic [1:0] count;
   } q_stat_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

### rtl/ssa_front.sv
// Front end: accepts request words, keeps the dof map and classifies items.
// Depends on ssa_pkg.
module ssa_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ssa_pkg::ReqDataW-1:0]   req_tdata,
   input  logic [2:0]                     req_tuser,
   input  ssa_pkg::back_stat_type         back_stat,
   input  ssa_pkg::q_stat_type            q_stat,
   output logic                           q_push,
   output ssa_pkg::entry_type             q_entry
);
   import ssa_pkg::*;

   logic              hold_ff;
   logic              hold_in;
   logic [2:0]        cmd_ff;
   logic [11:0]       row_ff;
   logic [11:0]       col_ff;
   logic [15:0]       addr_ff;
   logic [16:0]       data_ff;
   logic [31:0]       vre_ff;
   logic [31:0]       vim_ff;
   logic [13:0]       rword_ff;
   logic [13:0]       cword_ff;
   logic [13:0]       dof_mem [DofDepth];
   logic              accept;
   logic [2:0]        cmd;
   logic [15:0]       addr;
   logic [16:0]       data;

   assign cmd  = req_tuser;
   assign addr = req_tdata[39:24];
   assign data = req_tdata[56:40];

   assign q_push     = hold_ff && !q_stat.full;
   assign req_tready = !back_stat.clearing && (!hold_ff || q_push);
   assign accept     = req_tvalid && req_tready;
   assign hold_in    = accept || (hold_ff && !q_push);

   // hold the staged item
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      if (accept) begin
         cmd_ff  <= cmd;
         row_ff  <= req_tdata[11:0];
         col_ff  <= req_tdata[23:12];
         addr_ff <= addr;
         data_ff <= data;
         vre_ff  <= req_tdata[88:57];
         vim_ff  <= req_tdata[120:89];
      end
   end

   // dof map: constrained flag over equation number
   always_ff @(posedge clock) begin
      if (accept && cmd == CMD_DOF_WR && addr < 16'(DofDepth)) begin
         dof_mem[addr[DofAw-1:0]] <= {data == CONSTRAINED_WORD, data[12:0]};
      end
      if (accept) begin
         rword_ff <= dof_mem[req_tdata[DofAw-1:0]];
         cword_ff <= dof_mem[req_tdata[12+DofAw-1:12]];
      end
   end

   // classify the staged item
   always_comb begin
      q_entry        = '0;
      q_entry.op     = OP_IMMEDIATE;
      q_entry.status = ST_DONE;
      q_entry.addr   = addr_ff;
      q_entry.data   = data_ff;
      q_entry.eq_r   = rword_ff[12:0];
      q_entry.eq_c   = cword_ff[12:0];
      q_entry.vre    = vre_ff;
      q_entry.vim    = vim_ff;
      case (cmd_ff)
         CMD_DOF_WR: begin
            if (addr_ff >= 16'(DofDepth)) q_entry.status = ST_NO_POS;
         end
         CMD_COL_WR: begin
            if (addr_ff > 16'(EqDepth)) q_entry.status = ST_NO_POS;
            else q_entry.op = OP_COL_WR;
         end
         CMD_ROW_WR: q_entry.op = OP_ROW_WR;
         CMD_READ:   q_entry.op = OP_READ;
         CMD_VAL_WR: q_entry.op = OP_VAL_WR;
         CMD_ACCUM: begin
            q_entry.addr = '0;
            if (rword_ff[13]) q_entry.status = ST_CONSTRAINED;
            else if (row_ff > col_ff) q_entry.status = ST_LOWER;
            else if (cword_ff[13]) q_entry.status = ST_CONSTRAINED;
            else if (cword_ff[12:0] >= 13'(EqDepth)) q_entry.status = ST_NO_POS;
            else q_entry.op = OP_ACCUM;
         end
         default: q_entry.addr = '0;
      endcase
   end

endmodule

### rtl/ssa_queue.sv
// Short queue of classified words between front and back.
// Depends on ssa_pkg.
module ssa_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  ssa_pkg::q_ctrl_type  ctrl,
   input  ssa_pkg::entry_type   wr_entry,
   output ssa_pkg::entry_type   rd_entry,
   output ssa_pkg::q_stat_type  stat
);
   import ssa_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   entry_type              slot_ff [QueueDepth];
   logic [PtrW-1:0]        wptr_ff;
   logic [PtrW-1:0]        wptr_in;
   logic [PtrW-1:0]        rptr_ff;
   logic [PtrW-1:0]        rptr_in;
   logic [PtrW:0]          count_ff;
   logic [PtrW:0]          count_in;

   assign rd_entry   = slot_ff[rptr_ff];
   assign stat.full  = count_ff == (PtrW+1)'(QueueDepth);
   assign stat.empty = count_ff == '0;
   assign stat.count = 2'(count_ff);

   // advance pointers and count
   always_comb begin
      wptr_in  = ctrl.push ? PtrW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = ctrl.pop ? PtrW'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (ctrl.push && !ctrl.pop) count_in = count_ff + 1'b1;
      if (ctrl.pop && !ctrl.push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (ctrl.push) slot_ff[wptr_ff] <= wr_entry;
   end

endmodule

### rtl/ssa_back.sv
// Back end: column tables, value store, column search and saturating add.
// Depends on ssa_pkg.
module ssa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ssa_pkg::entry_type            head,
   input  ssa_pkg::q_stat_type           q_stat,
   output logic                          q_pop,
   output ssa_pkg::back_stat_type        stat,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ssa_pkg::RspDataW-1:0]  rsp_tdata,
   output logic [2:0]                    rsp_tuser
);
   import ssa_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_COL, S_SCAN, S_ROWCHK, S_VALRD, S_OUT
   } state_type;

   localparam logic signed [47:0] QMax = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] QMin = {1'b1, {47{1'b0}}};

   state_type           state_ff, state_in;
   logic [NzAw:0]       clr_ff, clr_in;
   logic [15:0]         addr_ff, addr_in;
   logic [13:0]         key_ff, key_in;
   logic [31:0]         vre_ff, vre_in, vim_ff, vim_in;
   logic [16:0]         m_ff, m_in, stop_ff, stop_in;
   logic [NzAw-1:0]     p_ff, p_in;
   logic [2:0]          st_ff, st_in;
   logic [15:0]         pos_ff, pos_in;
   logic [47:0]         re_ff, re_in, im_ff, im_in;

   logic [16:0]         col_mem [EqDepth+1];
   logic [12:0]         row_mem [NzDepth];
   logic [95:0]         val_mem [NzDepth];
   logic [16:0]         cs0_ff, cs1_ff;
   logic [12:0]         row_q_ff;
   logic [95:0]         val_q_ff;

   logic                col_we, row_we, val_we;
   logic [EqAw-1:0]     col_wa, col_ra0, col_ra1;
   logic [NzAw-1:0]     row_a, val_ra, val_wa;
   logic [95:0]         val_wd;
   logic [48:0]         sum_re, sum_im;
   logic [47:0]         new_re, new_im;
   logic                sat;

   assign stat.clearing = state_ff == S_CLEAR;
   assign rsp_tvalid    = state_ff == S_OUT;
   assign rsp_tdata     = {im_ff, re_ff, pos_ff};
   assign rsp_tuser     = st_ff;

   assign col_wa  = head.addr[EqAw-1:0];
   assign col_ra0 = head.eq_c;
   assign col_ra1 = EqAw'(head.eq_c + 1'b1);
   assign row_a   = NzAw'(m_ff - 1'b1);

   // saturating add of the stored word and the incoming Q16.16 parts
   always_comb begin
      sum_re = {val_q_ff[47], val_q_ff[47:0]} + {{17{vre_ff[31]}}, vre_ff};
      sum_im = {val_q_ff[95], val_q_ff[95:48]} + {{17{vim_ff[31]}}, vim_ff};
      new_re = sum_re[47:0];
      new_im = sum_im[47:0];
      sat    = 1'b0;
      if (sum_re[48] != sum_re[47]) begin
         new_re = sum_re[48] ? QMin : QMax;
         sat    = 1'b1;
      end
      if (sum_im[48] != sum_im[47]) begin
         new_im = sum_im[48] ? QMin : QMax;
         sat    = 1'b1;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      addr_in  = addr_ff;
      key_in   = key_ff;
      vre_in   = vre_ff;
      vim_in   = vim_ff;
      m_in     = m_ff;
      stop_in  = stop_ff;
      p_in     = p_ff;
      st_in    = st_ff;
      pos_in   = pos_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      q_pop    = 1'b0;
      col_we   = 1'b0;
      row_we   = 1'b0;
      val_we   = 1'b0;
      val_wa   = head.addr[NzAw-1:0];
      val_wd   = {{16{head.vim[31]}}, head.vim, {16{head.vre[31]}}, head.vre};
      val_ra   = head.addr[NzAw-1:0];
      case (state_ff)
         S_CLEAR: begin
            val_we = 1'b1;
            val_wa = clr_ff[NzAw-1:0];
            val_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff[NzAw]) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!q_stat.empty) begin
               q_pop   = 1'b1;
               addr_in = head.addr;
               key_in  = {1'b0, head.eq_r} + 14'd1;
               vre_in  = head.vre;
               vim_in  = head.vim;
               st_in   = head.status;
               pos_in  = head.addr;
               re_in   = '0;
               im_in   = '0;
               state_in = S_OUT;
               case (head.op)
                  OP_COL_WR: col_we = 1'b1;
                  OP_ROW_WR: row_we = 1'b1;
                  OP_VAL_WR: begin
                     val_we = 1'b1;
                     re_in  = val_wd[47:0];
                     im_in  = val_wd[95:48];
                  end
                  OP_READ:  state_in = S_READ;
                  OP_ACCUM: state_in = S_COL;
                  default: ;
               endcase
            end
         end
         S_READ: begin
            re_in    = val_q_ff[47:0];
            im_in    = val_q_ff[95:48];
            state_in = S_OUT;
         end
         S_COL: begin
            m_in     = cs0_ff;
            stop_in  = cs1_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (m_ff >= stop_ff) begin
               st_in    = ST_NO_POS;
               pos_in   = '0;
               state_in = S_OUT;
            end else if (m_ff == '0 || m_ff > 17'(NzDepth)) begin
               m_in = m_ff + 1'b1;
            end else begin
               p_in     = row_a;
               state_in = S_ROWCHK;
            end
         end
         S_ROWCHK: begin
            val_ra = p_ff;
            if ({1'b0, row_q_ff} == key_ff) begin
               state_in = S_VALRD;
            end else begin
               m_in     = m_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_VALRD: begin
            val_we   = 1'b1;
            val_wa   = p_ff;
            val_wd   = {new_im, new_re};
            st_in    = sat ? ST_SATURATED : ST_DONE;
            pos_in   = 16'(p_ff);
            re_in    = new_re;
            im_in    = new_im;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      addr_ff <= addr_in;
      key_ff  <= key_in;
      vre_ff  <= vre_in;
      vim_ff  <= vim_in;
      m_ff    <= m_in;
      stop_ff <= stop_in;
      p_ff    <= p_in;
      st_ff   <= st_in;
      pos_ff  <= pos_in;
      re_ff   <= re_in;
      im_ff   <= im_in;
   end

   // column start table, two read ports
   always_ff @(posedge clock) begin
      if (col_we) col_mem[col_wa] <= head.data;
      cs0_ff <= col_mem[col_ra0];
      cs1_ff <= col_mem[col_ra1];
   end

   // row index table
   always_ff @(posedge clock) begin
      if (row_we) row_mem[head.addr[NzAw-1:0]] <= head.data[12:0];
      row_q_ff <= row_mem[row_a];
   end

   // value store, real part in the low half
   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_wa] <= val_wd;
      val_q_ff <= val_mem[val_ra];
   end

endmodule

### rtl/sparse_symmetric_scatter_add_top.sv
// Top level of the sparse symmetric scatter-add block.
// Depends on ssa_pkg, ssa_front, ssa_queue and ssa_back.
//
//   channel | dir | tdata fields (low bit up)                        | tuser
//   req     | in  | row_dof, col_dof, table_addr, table_data,       | command
//           |     | value_re, value_im, zero pad to 128             |
//   rsp     | out | position, read_re, read_im                      | status
//
// After reset the value store is cleared, one entry a cycle, with req_tready
// low. An accumulate searches the row entries of its column one at a time,
// through the single row-table read port; pointers outside range are skipped.
// The front keeps taking words into a two-entry queue while a result stalls,
// until that queue is full.
module sparse_symmetric_scatter_add_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // row_dof, col_dof, table_addr, table_data, re, im
   input  logic [2:0]    req_tuser,  // command
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,  // position, read_re, read_im
   output logic [2:0]    rsp_tuser   // status
);
   import ssa_pkg::*;

   entry_type      push_entry;
   entry_type      head;
   q_ctrl_type     q_ctrl;
   q_stat_type     q_stat;
   back_stat_type  back_stat;
   logic           q_push;
   logic           q_pop;

   assign q_ctrl.push = q_push;
   assign q_ctrl.pop  = q_pop;

   ssa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .back_stat  (back_stat),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   ssa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .wr_entry (push_entry),
      .rd_entry (head),
      .stat     (q_stat)
   );

   ssa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .stat       (back_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // no word taken while the value store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      back_stat.clearing |-> !req_tready)
      else $error("request taken during clear");

   // no result offered while clearing
   assert property (@(posedge clock) disable iff (reset)
      back_stat.clearing |-> !rsp_tvalid)
      else $error("result during clear");

   // queue never pushed when full nor popped when empty
   assert property (@(posedge clock) disable iff (reset)
      !(q_ctrl.push && q_stat.full) && !(q_ctrl.pop && q_stat.empty))
      else $error("queue misuse");

endmodule
